@@ sv/imi_pkg.sv @@
// Shared types, constants and the function-name trie for the implicit multiply inserter.
package imi_pkg;

    typedef enum logic [2:0] {
        KIND_NONE  = 3'd0,
        KIND_NUM   = 3'd1,
        KIND_IDENT = 3'd2,
        KIND_OP    = 3'd3,
        KIND_LPAR  = 3'd4,
        KIND_RPAR  = 3'd5
    } t_kind;

    typedef logic [4:0] t_node;

    localparam t_node NODE_NONE = 5'd0;
    localparam t_node NODE_ROOT = 5'd31;

    // Terminal nodes of the trie, one per function name
    localparam t_node NODE_SIN   = 5'd3;
    localparam t_node NODE_COS   = 5'd6;
    localparam t_node NODE_CTG   = 5'd8;
    localparam t_node NODE_TAN   = 5'd11;
    localparam t_node NODE_LN    = 5'd13;
    localparam t_node NODE_LOG2  = 5'd16;
    localparam t_node NODE_LOG10 = 5'd18;

    localparam logic [7:0] CH_STAR = 8'h2A;

    // One lexer decision: the kept byte, and whether a '*' goes in front of it
    typedef struct packed {
        logic       emit;
        logic       ins;
        logic [7:0] ch;
    } t_lex_res;

    function automatic t_node name_advance(input t_node node, input logic [7:0] c);
        t_node nxt;
        nxt = NODE_NONE;
        case (node)
            NODE_ROOT: begin
                if (c == "s") nxt = 5'd1;
                else if (c == "c") nxt = 5'd4;
                else if (c == "t") nxt = 5'd9;
                else if (c == "l") nxt = 5'd12;
            end
            5'd1:  if (c == "i") nxt = 5'd2;
            5'd2:  if (c == "n") nxt = NODE_SIN;
            5'd4: begin
                if (c == "o") nxt = 5'd5;
                else if (c == "t") nxt = 5'd7;
            end
            5'd5:  if (c == "s") nxt = NODE_COS;
            5'd7:  if (c == "g") nxt = NODE_CTG;
            5'd9:  if (c == "a") nxt = 5'd10;
            5'd10: if (c == "n") nxt = NODE_TAN;
            5'd12: begin
                if (c == "n") nxt = NODE_LN;
                else if (c == "o") nxt = 5'd14;
            end
            5'd14: if (c == "g") nxt = 5'd15;
            5'd15: begin
                if (c == "2") nxt = NODE_LOG2;
                else if (c == "1") nxt = 5'd17;
            end
            5'd17: if (c == "0") nxt = NODE_LOG10;
            default: nxt = NODE_NONE;
        endcase
        return nxt;
    endfunction

    function automatic logic is_func_name(input t_node node);
        return (node == NODE_SIN) || (node == NODE_COS) || (node == NODE_CTG) ||
               (node == NODE_TAN) || (node == NODE_LN) || (node == NODE_LOG2) ||
               (node == NODE_LOG10);
    endfunction

endpackage

@@ sv/imi_in_if.sv @@
// Input channel: one expression byte per transfer.
interface imi_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       start_of_expression;

    modport source (output valid, output char_code, output start_of_expression, input ready);
    modport sink   (input valid, input char_code, input start_of_expression, output ready);
endinterface

@@ sv/imi_out_if.sv @@
// Output channel: one emitted byte per transfer.
interface imi_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_of_run;

    modport source (output valid, output out_char, output last_of_run, input ready);
    modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface

@@ sv/imi_lexer.sv @@
// Token state and classification: decides per byte what to emit and updates state.
module imi_lexer
    import imi_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_char,
    input  logic       i_start,
    output t_lex_res   o_res
);

    t_kind r_prev_kind, n_prev_kind;
    logic  r_token_open, n_token_open;
    t_node r_name_match, n_name_match;

    t_kind cur_kind;
    logic  cur_open;
    t_node cur_match;
    logic  is_digit, is_alpha, is_space, is_num_ch, is_id_ch, is_op;
    logic  kind_valid;
    t_kind new_kind;

    always_comb begin
        // start flag clears the token state before this byte
        cur_kind  = i_start ? KIND_NONE : r_prev_kind;
        cur_open  = i_start ? 1'b0 : r_token_open;
        cur_match = i_start ? NODE_NONE : r_name_match;

        is_digit  = (i_char >= "0") && (i_char <= "9");
        is_alpha  = ((i_char >= "a") && (i_char <= "z")) ||
                    ((i_char >= "A") && (i_char <= "Z"));
        is_space  = (i_char == " ") || ((i_char >= 8'd9) && (i_char <= 8'd13));
        is_num_ch = is_digit || (i_char == ".");
        is_id_ch  = is_alpha || (i_char == "_");
        is_op     = (i_char == "+") || (i_char == "-") || (i_char == "*") ||
                    (i_char == "/") || (i_char == "^");

        kind_valid = 1'b1;
        if (is_num_ch)            new_kind = KIND_NUM;
        else if (is_id_ch)        new_kind = KIND_IDENT;
        else if (is_op)           new_kind = KIND_OP;
        else if (i_char == "(")   new_kind = KIND_LPAR;
        else if (i_char == ")")   new_kind = KIND_RPAR;
        else begin
            new_kind   = KIND_NONE;
            kind_valid = 1'b0;
        end

        n_prev_kind  = cur_kind;
        n_token_open = cur_open;
        n_name_match = cur_match;
        o_res.emit   = 1'b0;
        o_res.ins    = 1'b0;
        o_res.ch     = i_char;

        if (is_space) begin
            // dropped, state untouched
        end else if (cur_open && (cur_kind == KIND_NUM) && is_num_ch) begin
            o_res.emit = 1'b1;
        end else if (cur_open && (cur_kind == KIND_IDENT) && (is_id_ch || is_digit)) begin
            o_res.emit   = 1'b1;
            n_name_match = name_advance(cur_match, i_char);
        end else if (!kind_valid) begin
            // unknown byte closes the open token
            n_token_open = 1'b0;
        end else begin
            o_res.emit = 1'b1;
            o_res.ins  = ((cur_kind == KIND_NUM) || (cur_kind == KIND_IDENT) ||
                          (cur_kind == KIND_RPAR)) &&
                         ((new_kind == KIND_NUM) || (new_kind == KIND_IDENT) ||
                          (new_kind == KIND_LPAR)) &&
                         !((cur_kind == KIND_IDENT) && is_func_name(cur_match) &&
                           (new_kind == KIND_LPAR));
            n_prev_kind  = new_kind;
            n_token_open = (new_kind == KIND_NUM) || (new_kind == KIND_IDENT);
            n_name_match = (new_kind == KIND_IDENT) ? name_advance(NODE_ROOT, i_char)
                                                    : NODE_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_kind  <= KIND_NONE;
            r_token_open <= 1'b0;
            r_name_match <= NODE_NONE;
        end else if (i_accept) begin
            r_prev_kind  <= n_prev_kind;
            r_token_open <= n_token_open;
            r_name_match <= n_name_match;
        end
    end

endmodule

@@ sv/imi_out_stage.sv @@
// Result register: holds one lexer decision and plays it out as one or two transfers.
module imi_out_stage
    import imi_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_lex_res  i_res,
    output logic      o_can_load,
    imi_out_if.source o_out
);

    logic       r_full, n_full;
    logic       r_ins, n_ins;
    logic [7:0] r_char;
    logic       xfer;

    assign xfer       = o_out.valid && o_out.ready;
    // free now, or the final transfer of the held result happens this cycle
    assign o_can_load = !r_full || (xfer && !r_ins);

    assign o_out.valid       = r_full;
    assign o_out.out_char    = r_ins ? CH_STAR : r_char;
    assign o_out.last_of_run = !r_ins;

    always_comb begin
        n_full = r_full;
        n_ins  = r_ins;
        if (xfer) begin
            if (r_ins) n_ins = 1'b0;
            else n_full = 1'b0;
        end
        if (i_load) begin
            n_full = 1'b1;
            n_ins  = i_res.ins;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_ins  <= 1'b0;
        end else begin
            r_full <= n_full;
            r_ins  <= n_ins;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_char <= i_res.ch;
        end
    end

endmodule

@@ sv/implicit_multiply_inserter.sv @@
// Implicit multiply inserter: top level joining the lexer and the result register.
// Takes one expression byte per transfer and emits the kept bytes with '*' inserted
// between adjacent operands (not between a function name and '('). Whitespace and
// unknown bytes give no output. A byte is taken every cycle while the result register
// is free or draining its last beat; a byte that needs an inserted '*' holds the result
// register for two output beats. The first output beat is offered in the cycle after the
// input transfer.
module implicit_multiply_inserter
    import imi_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    imi_in_if.sink   i_in,
    imi_out_if.source o_out
);

    t_lex_res lex_res;
    logic     can_load;
    logic     accept;

    assign i_in.ready = can_load;
    assign accept     = i_in.valid && can_load;

    imi_lexer u_lexer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_char   (i_in.char_code),
        .i_start  (i_in.start_of_expression),
        .o_res    (lex_res)
    );

    imi_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept && lex_res.emit),
        .i_res      (lex_res),
        .o_can_load (can_load),
        .o_out      (o_out)
    );

endmodule

@@ tb/implicit_multiply_inserter_tb.sv @@
// Testbench for implicit_multiply_inserter: random and directed expression text, scoreboarded output.
module implicit_multiply_inserter_tb;
    import imi_pkg::*;

    localparam int unsigned CALM_FROM  = 2000;    // cycles with no idling on either side
    localparam int unsigned CALM_TO    = 4500;
    localparam int          TEXT_ITEMS = 2000;
    localparam int          DRAIN_WAIT = 20;

    typedef struct packed {
        logic [7:0] ch;
        logic       sos;
    } t_text_byte;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_out_beat;

    logic i_clk;
    logic i_rst_n;

    imi_in_if  in_ch();
    imi_out_if out_ch();

    implicit_multiply_inserter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_text_byte  text_q[$];
    t_out_beat   out_bytes_due[$];
    int unsigned cycle_count = 0;
    int          fail_count = 0;
    int          nonblank_queued = 0;
    int          bytes_taken = 0;
    int          beats_checked = 0;
    int          stars_inserted = 0;
    int          expr_count = 0;

    // Lexer state mirrored from the block
    t_kind lx_kind;
    logic  lx_open;
    t_node lx_node;

    string name_pool[11] = '{"sin", "cos", "tan", "ctg", "ln", "log2", "log10",
                             "si", "co", "lo", "log1"};

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    // Walk the function-name trie by one character; NODE_NONE once off every name
    function automatic t_node trie_step(input t_node from, input logic [7:0] c);
        case ({from, c})
            {NODE_ROOT, "s"}: return 5'd1;
            {5'd1, "i"}:      return 5'd2;
            {5'd2, "n"}:      return NODE_SIN;
            {NODE_ROOT, "c"}: return 5'd4;
            {5'd4, "o"}:      return 5'd5;
            {5'd5, "s"}:      return NODE_COS;
            {5'd4, "t"}:      return 5'd7;
            {5'd7, "g"}:      return NODE_CTG;
            {NODE_ROOT, "t"}: return 5'd9;
            {5'd9, "a"}:      return 5'd10;
            {5'd10, "n"}:     return NODE_TAN;
            {NODE_ROOT, "l"}: return 5'd12;
            {5'd12, "n"}:     return NODE_LN;
            {5'd12, "o"}:     return 5'd14;
            {5'd14, "g"}:     return 5'd15;
            {5'd15, "2"}:     return NODE_LOG2;
            {5'd15, "1"}:     return 5'd17;
            {5'd17, "0"}:     return NODE_LOG10;
            default:          return NODE_NONE;
        endcase
    endfunction

    task automatic push_beat(input logic [7:0] c, input logic last);
        out_bytes_due.insert(out_bytes_due.size(), t_out_beat'{ch: c, last: last});
    endtask

    // Lex one accepted byte and queue the bytes it should produce
    task automatic lex_and_insert(input logic [7:0] c, input logic sos);
        t_kind kind;
        logic  ins;
        logic  at_func;
        if (sos) begin
            lx_kind = KIND_NONE;
            lx_open = 1'b0;
            lx_node = NODE_NONE;
        end
        if (is_blank(c))
            return;
        if (lx_open && lx_kind == KIND_NUM && (is_digit(c) || c == ".")) begin
            push_beat(c, 1'b1);
            return;
        end
        if (lx_open && lx_kind == KIND_IDENT && (is_letter(c) || is_digit(c) || c == "_")) begin
            lx_node = trie_step(lx_node, c);
            push_beat(c, 1'b1);
            return;
        end
        if (is_digit(c) || c == ".")
            kind = KIND_NUM;
        else if (is_letter(c) || c == "_")
            kind = KIND_IDENT;
        else if (c == "+" || c == "-" || c == "*" || c == "/" || c == "^")
            kind = KIND_OP;
        else if (c == "(")
            kind = KIND_LPAR;
        else if (c == ")")
            kind = KIND_RPAR;
        else begin
            // unknown byte: closes the token, keeps kind and name match
            lx_open = 1'b0;
            return;
        end
        at_func = lx_node == NODE_SIN || lx_node == NODE_COS || lx_node == NODE_TAN ||
                  lx_node == NODE_CTG || lx_node == NODE_LN || lx_node == NODE_LOG2 ||
                  lx_node == NODE_LOG10;
        ins = (lx_kind == KIND_NUM || lx_kind == KIND_IDENT || lx_kind == KIND_RPAR) &&
              (kind == KIND_NUM || kind == KIND_IDENT || kind == KIND_LPAR) &&
              !(lx_kind == KIND_IDENT && at_func && kind == KIND_LPAR);
        lx_kind = kind;
        lx_open = (kind == KIND_NUM || kind == KIND_IDENT);
        lx_node = (kind == KIND_IDENT) ? trie_step(NODE_ROOT, c) : NODE_NONE;
        if (ins) begin
            push_beat(CH_STAR, 1'b0);
            stars_inserted++;
        end
        push_beat(c, 1'b1);
    endtask

    function automatic logic take_a_break();
        return (cycle_count < CALM_FROM || cycle_count >= CALM_TO) && $urandom_range(99) < 38;
    endfunction

    task automatic queue_byte(input logic [7:0] c, input logic sos);
        text_q.insert(text_q.size(), t_text_byte'{ch: c, sos: sos});
        if (!is_blank(c))
            nonblank_queued++;
    endtask

    task automatic queue_text(input string s, input logic sos_first);
        for (int i = 0; i < s.len(); i++)
            queue_byte(s[i], sos_first && i == 0);
        expr_count++;
    endtask

    function automatic logic [7:0] ident_char();
        int r;
        r = $urandom_range(62);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        if (r < 62) return 8'("0" + r - 52);
        return "_";
    endfunction

    // Mostly well-formed tokens with random content, plus blanks, junk and raw noise
    task automatic queue_random_expression();
        logic [7:0] tok[$];
        string      s;
        string      ops;
        string      junk;
        int         r;
        int         k;
        logic       first;
        ops = "+-*/^";
        junk = "#$%&!,;:=<>?@[]{}|~`'\"\\";
        first = 1'b1;
        repeat ($urandom_range(1, 12)) begin
            tok.delete();
            r = $urandom_range(99);
            if (r < 22) begin
                repeat ($urandom_range(1, 4))
                    tok.insert(tok.size(), ($urandom_range(6) == 0) ?
                               8'h2E : 8'("0" + $urandom_range(9)));
            end else if (r < 44) begin
                if ($urandom_range(1)) begin
                    s = name_pool[$urandom_range(10)];
                    for (int i = 0; i < s.len(); i++)
                        tok.insert(tok.size(), s[i]);
                    if ($urandom_range(6) == 0) begin
                        k = $urandom_range(tok.size() - 1);
                        if (tok[k] >= "a" && tok[k] <= "z")
                            tok[k] = tok[k] - 8'd32;
                    end
                    if ($urandom_range(3) == 0)
                        tok.insert(tok.size(), ident_char());
                    if ($urandom_range(1))
                        tok.insert(tok.size(), "(");
                end else begin
                    k = $urandom_range(52);
                    tok.insert(tok.size(), 8'(k < 26 ? "a" + k : (k < 52 ? "A" + k - 26 : "_")));
                    repeat ($urandom_range(3))
                        tok.insert(tok.size(), ident_char());
                end
            end else if (r < 60) begin
                tok.insert(tok.size(), ops[$urandom_range(4)]);
            end else if (r < 72) begin
                tok.insert(tok.size(), "(");
            end else if (r < 82) begin
                tok.insert(tok.size(), ")");
            end else if (r < 90) begin
                k = $urandom_range(5);
                tok.insert(tok.size(), 8'(k == 5 ? " " : 9 + k));
            end else if (r < 95) begin
                tok.insert(tok.size(), junk[$urandom_range(junk.len() - 1)]);
            end else begin
                tok.insert(tok.size(), 8'($urandom_range(255)));
            end
            foreach (tok[i]) begin
                queue_byte(tok[i], first);
                first = 1'b0;
            end
        end
        expr_count++;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk)
        cycle_count <= cycle_count + 1;

    // Input driver: holds an offered byte until its transfer, then maybe idles
    always @(posedge i_clk) begin : drive
        t_text_byte nxt;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                lex_and_insert(in_ch.char_code, in_ch.start_of_expression);
                bytes_taken++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (text_q.size() != 0 && !take_a_break()) begin
                    nxt = text_q.pop_front();
                    in_ch.char_code <= nxt.ch;
                    in_ch.start_of_expression <= nxt.sos;
                    in_ch.valid <= 1'b1;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor with random backpressure
    always @(posedge i_clk) begin : check
        t_out_beat due;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (out_bytes_due.size() == 0) begin
                    $error("output transfer 0x%02h with nothing expected", out_ch.out_char);
                    fail_count++;
                end else begin
                    due = out_bytes_due.pop_front();
                    beats_checked++;
                    if (out_ch.out_char !== due.ch) begin
                        $error("out_char: expected 0x%02h, got 0x%02h", due.ch, out_ch.out_char);
                        fail_count++;
                    end
                    if (out_ch.last_of_run !== due.last) begin
                        $error("last_of_run: expected %0b, got %0b", due.last,
                               out_ch.last_of_run);
                        fail_count++;
                    end
                end
            end
            out_ch.ready <= !take_a_break();
        end
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int directed_items;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.char_code = 8'h00;
        in_ch.start_of_expression = 1'b0;
        out_ch.ready = 1'b0;
        lx_kind = KIND_NONE;
        lx_open = 1'b0;
        lx_node = NODE_NONE;

        // numbers split by an unknown byte still get a '*'
        queue_text("2#3", 1'b1);
        // start on a blank clears state; name survives an unknown byte
        queue_text(" sin#(", 1'b1);
        // names match in lower case only
        queue_text("Cos(", 1'b1);
        queue_text(")(", 1'b0);
        queue_text("+-*/^", 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_text("log10(", 1'b1);
        directed_items = nonblank_queued;
        while (nonblank_queued - directed_items < TEXT_ITEMS)
            queue_random_expression();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (text_q.size() != 0 || in_ch.valid)
            @(posedge i_clk);
        while (out_bytes_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Fed %0d bytes over %0d expressions; checked %0d output bytes,",
                 bytes_taken, expr_count, beats_checked);
        $display("%0d of them inserted multiplies, with %0d mismatches.",
                 stars_inserted, fail_count);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ implicit_multiply_inserter.f @@
sv/imi_pkg.sv
sv/imi_in_if.sv
sv/imi_out_if.sv
sv/imi_lexer.sv
sv/imi_out_stage.sv
sv/implicit_multiply_inserter.sv
tb/implicit_multiply_inserter_tb.sv
